[src/music_transport_timebase_core_defines.svh]
// Assertion macros for the music transport timebase checker.
// Needs a clk and an active-low rst_n in the scope of use.
`ifndef MUSIC_TRANSPORT_TIMEBASE_CORE_DEFINES_SVH
`define MUSIC_TRANSPORT_TIMEBASE_CORE_DEFINES_SVH

// same-cycle implication
`define MTT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/mtt_pkg.sv]
// Shared types, codes and constants of the music transport timebase.
// No dependencies; every other file but the defines header imports it.
`default_nettype none
package mtt_pkg;

    localparam int TIME_W  = 48;
    localparam int OUT_W   = 47;
    localparam int TEMPO_W = 18;
    localparam int RATE_W  = 20;
    localparam int FRAME_W = 16;
    localparam int DELTA_W = 32;
    localparam int EPOCH_W = 16;
    localparam int MAG_W   = 49;
    localparam int PROD_W  = MAG_W + TEMPO_W;

    localparam logic [TEMPO_W-1:0] TEMPO_RESET = 18'd30720;
    localparam logic [RATE_W-1:0]  TEMPO_DIV   = 20'd15360;
    localparam logic signed [TIME_W-1:0] T_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [TIME_W-1:0] T_MIN = 48'sh8000_0000_0000;

    localparam logic [3:0] ACT_TICK       = 4'd0;
    localparam logic [3:0] ACT_AUDIO_ON   = 4'd1;
    localparam logic [3:0] ACT_AUDIO_OFF  = 4'd2;
    localparam logic [3:0] ACT_ADVANCE    = 4'd3;
    localparam logic [3:0] ACT_SEEK       = 4'd4;
    localparam logic [3:0] ACT_OFFLINE_ON = 4'd5;
    localparam logic [3:0] ACT_OFFLINE_OFF= 4'd6;
    localparam logic [3:0] ACT_VIDEO      = 4'd7;
    localparam logic [3:0] ACT_BLK_BEGIN  = 4'd8;
    localparam logic [3:0] ACT_BLK_END    = 4'd9;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ARG,
        OP_MUL,
        OP_DIV_TS,
        OP_DIV_AUD,
        OP_TS_FIN,
        OP_AUD_FIN,
        OP_SEL_S,
        OP_B_FIN,
        OP_APPLY,
        OP_OUT
    } op_t;

    typedef enum logic [1:0] {
        ARG_DELTA,
        ARG_TV,
        ARG_PEND,
        ARG_DIFF
    } arg_sel_t;

    typedef struct packed {
        op_t      op;
        arg_sel_t sel;
    } cmd_t;

    typedef struct packed {
        logic [3:0] action;
        logic       pending;
        logic       offline;
        logic       in_block;
        logic       rate_nz;
        logic       div_busy;
    } status_t;

    function automatic logic signed [TIME_W-1:0] sat48(input logic signed [TIME_W+1:0] v);
        logic signed [TIME_W-1:0] r;
        if ((v[TIME_W+1:TIME_W-1] == 3'b000) || (v[TIME_W+1:TIME_W-1] == 3'b111))
            r = v[TIME_W-1:0];
        else if (v[TIME_W+1])
            r = T_MIN;
        else
            r = T_MAX;
        return r;
    endfunction

    function automatic logic signed [TIME_W+1:0] ext50(input logic signed [TIME_W-1:0] v);
        return {{2{v[TIME_W-1]}}, v};
    endfunction

endpackage
`default_nettype wire

[src/mtt_if.sv]
// Channel interfaces of the music transport timebase: input beat and result beat.
// Depends on mtt_pkg for field widths.
`default_nettype none
interface mtt_in_if;
    import mtt_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [3:0]               action;
    logic                     playing;
    logic [DELTA_W-1:0]       delta_time;
    logic [FRAME_W-1:0]       frame_count;
    logic [RATE_W-1:0]        rate_hz;
    logic signed [TIME_W-1:0] time_value;

    modport source (output valid, action, playing, delta_time, frame_count, rate_hz,
                    time_value, input ready);
    modport sink (input valid, action, playing, delta_time, frame_count, rate_hz,
                  time_value, output ready);
endinterface

interface mtt_out_if;
    import mtt_pkg::*;
    logic               valid;
    logic               ready;
    logic [OUT_W-1:0]   seconds_now;
    logic [OUT_W-1:0]   beats_now;
    logic [EPOCH_W-1:0] epoch_count;
    logic               audio_driven;
    logic               offline_on;

    modport source (output valid, seconds_now, beats_now, epoch_count, audio_driven,
                    offline_on, input ready);
    modport sink (input valid, seconds_now, beats_now, epoch_count, audio_driven,
                  offline_on, output ready);
endinterface
`default_nettype wire

[src/mtt_div.sv]
// Restoring serial divider, one quotient bit per cycle.
// Depends on mtt_pkg for the divisor width.
`default_nettype none
module mtt_div
    import mtt_pkg::*;
#(
    parameter int W = 72
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [W-1:0]      dividend,
    input  wire logic [RATE_W-1:0] divisor,
    output logic                   busy,
    output logic [W-1:0]           quotient
);
    localparam int CNT_W = $clog2(W + 1);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [W-1:0]      dvd_reg, dvd_next;
    logic [RATE_W-1:0] rem_reg, rem_next;
    logic [RATE_W-1:0] dsr_reg, dsr_next;
    logic [RATE_W:0]   shifted;
    logic [RATE_W:0]   trial;

    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[W-1]};
        trial    = shifted - {1'b0, dsr_reg};
        cnt_next = cnt_reg;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        if (start)
        begin
            cnt_next = CNT_W'(W);
            dvd_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (!trial[RATE_W])
            begin
                rem_next = trial[RATE_W-1:0];
                dvd_next = {dvd_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[RATE_W-1:0];
                dvd_next = {dvd_reg[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = dvd_reg;
endmodule
`default_nettype wire

[src/mtt_dpath.sv]
// Datapath: transport state, tempo register, multiplier, serial divider for audio time,
// digit-serial divide by the tempo constant, result registers.
// Depends on mtt_pkg and mtt_div; driven by mtt_ctrl commands.
`default_nettype none
module mtt_dpath
    import mtt_pkg::*;
#(
    parameter int FRAC_BITS = 24
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cmd_t                     cmd,
    output status_t                       status,
    input  wire logic                     tempo_we,
    input  wire logic [TEMPO_W-1:0]       tempo_wdata,
    input  wire logic [3:0]               action,
    input  wire logic                     playing,
    input  wire logic [DELTA_W-1:0]       delta_time,
    input  wire logic [FRAME_W-1:0]       frame_count,
    input  wire logic [RATE_W-1:0]        rate_hz,
    input  wire logic signed [TIME_W-1:0] time_value,
    output logic [OUT_W-1:0]              seconds_now,
    output logic [OUT_W-1:0]              beats_now,
    output logic [EPOCH_W-1:0]            epoch_count,
    output logic                          audio_driven,
    output logic                          offline_on
);
    localparam int DIV_W = TIME_W + FRAC_BITS;
    localparam int TS_SHIFT = 10;
    localparam int DQ_W = 60;
    localparam logic [DELTA_W-1:0] DELTA_LIM = DELTA_W'(64'd1 << (FRAC_BITS - 2));
    localparam logic signed [TIME_W-1:0] T_MIN_MAG = T_MIN;

    logic [TEMPO_W-1:0]       tempo_reg;
    logic signed [TIME_W-1:0] fsec_reg, fbeat_reg, soff_reg, boff_reg, pend_t_reg, video_reg;
    logic [TIME_W-1:0]        fc_reg;
    logic [RATE_W-1:0]        rate_reg;
    logic                     pend_reg, offline_reg, in_blk_reg;
    logic [EPOCH_W-1:0]       epoch_reg;

    logic [3:0]               act_reg;
    logic                     play_reg;
    logic [DELTA_W-1:0]       delta_reg;
    logic [FRAME_W-1:0]       frames_reg;
    logic [RATE_W-1:0]        rate_in_reg;
    logic signed [TIME_W-1:0] tv_reg;

    logic signed [MAG_W-1:0]  arg_reg, arg_next;
    logic [PROD_W-1:0]        prod_reg;
    logic signed [TIME_W-1:0] ts_reg, s_reg, b_reg;

    logic [DQ_W-1:0]          dq_reg;
    logic [3:0]               drem_reg;
    logic [3:0]               dcnt_reg;
    logic [7:0]               dv;
    logic [11:0]              dv_m;
    logic [3:0]               dqd;
    logic [7:0]               dv_r;
    logic                     dc_busy;

    logic [DELTA_W-1:0]       delta_c;
    logic signed [TIME_W-1:0] tv_c;
    logic [MAG_W-1:0]         mag;
    logic                     div_start, div_busy;
    logic [DIV_W-1:0]         div_dvd, quo;
    logic [RATE_W-1:0]        div_dsr;
    logic                     big, big_ts;
    logic signed [TIME_W-1:0] q_sat, q_ts, ts_val, aud_val, b_val;
    logic [TIME_W-1:0]        fc_base;
    logic [TIME_W:0]          fc_sum;
    logic [TIME_W-1:0]        fc_adv;

    assign delta_c = (delta_reg > DELTA_LIM) ? DELTA_LIM : delta_reg;
    assign tv_c    = tv_reg[TIME_W-1] ? '0 : tv_reg;
    assign mag     = arg_reg[MAG_W-1] ? MAG_W'(-arg_reg) : MAG_W'(arg_reg);

    always_comb
    begin
        case (cmd.sel)
            ARG_DELTA: arg_next = {{(MAG_W-DELTA_W){1'b0}}, delta_c};
            ARG_TV:    arg_next = {tv_c[TIME_W-1], tv_c};
            ARG_PEND:  arg_next = {pend_t_reg[TIME_W-1], pend_t_reg};
            default:   arg_next = {s_reg[TIME_W-1], s_reg} - {soff_reg[TIME_W-1], soff_reg};
        endcase
    end

    assign div_start = (cmd.op == OP_DIV_AUD);
    assign div_dvd   = DIV_W'(fc_reg) << FRAC_BITS;
    assign div_dsr   = rate_reg;

    mtt_div #(.W(DIV_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .busy     (div_busy),
        .quotient (quo)
    );

    // divide by 15360: drop ten bits, then long division by 15, one hex digit a cycle
    assign dv    = {drem_reg, dq_reg[DQ_W-1:DQ_W-4]};
    assign dv_m  = (12'(dv) + 12'd1) * 12'd17;
    assign dqd   = dv_m[11:8];
    assign dv_r  = dv - ({dqd, 4'b0000} - {4'b0000, dqd});
    assign dc_busy = (dcnt_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dcnt_reg <= '0;
        else if (cmd.op == OP_DIV_TS)
            dcnt_reg <= 4'd15;
        else if (dcnt_reg != '0)
            dcnt_reg <= dcnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_DIV_TS)
        begin
            dq_reg   <= {{(DQ_W-PROD_W+TS_SHIFT){1'b0}}, prod_reg[PROD_W-1:TS_SHIFT]};
            drem_reg <= '0;
        end
        else if (dcnt_reg != '0)
        begin
            dq_reg   <= {dq_reg[DQ_W-5:0], dqd};
            drem_reg <= dv_r[3:0];
        end
    end

    assign big    = |quo[DIV_W-1:OUT_W];
    assign q_sat  = big ? T_MAX : {1'b0, quo[OUT_W-1:0]};
    assign big_ts = |dq_reg[DQ_W-1:OUT_W];
    assign q_ts   = big_ts ? T_MAX : {1'b0, dq_reg[OUT_W-1:0]};

    always_comb
    begin
        if (arg_reg[MAG_W-1])
            ts_val = big_ts ? T_MIN_MAG : -q_ts;
        else
            ts_val = q_ts;
    end

    assign aud_val = sat48(ext50(soff_reg) + ext50(q_sat));

    always_comb
    begin
        if (pend_reg)
            b_val = ts_reg;
        else if ((rate_reg == '0) && !offline_reg)
            b_val = fbeat_reg;
        else
            b_val = sat48(ext50(boff_reg) + ext50(ts_reg));
        if (b_val[TIME_W-1])
            b_val = '0;
    end

    assign fc_base = pend_reg ? '0 : fc_reg;
    assign fc_sum  = {1'b0, fc_base} + (TIME_W+1)'(frames_reg);
    assign fc_adv  = fc_sum[TIME_W] ? '1 : fc_sum[TIME_W-1:0];

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tempo_reg   <= TEMPO_RESET;
            fsec_reg    <= '0;
            fbeat_reg   <= '0;
            soff_reg    <= '0;
            boff_reg    <= '0;
            fc_reg      <= '0;
            rate_reg    <= '0;
            pend_reg    <= 1'b0;
            pend_t_reg  <= '0;
            offline_reg <= 1'b0;
            in_blk_reg  <= 1'b0;
            video_reg   <= '0;
            epoch_reg   <= '0;
            act_reg     <= ACT_TICK;
        end
        else
        begin
            if (tempo_we)
                tempo_reg <= tempo_wdata;
            if (cmd.op == OP_LOAD)
                act_reg <= action;
            if (cmd.op == OP_APPLY)
            begin
                case (act_reg)
                    ACT_TICK:
                    begin
                        if (!offline_reg && (rate_reg == '0) && play_reg)
                        begin
                            fsec_reg  <= sat48(ext50(fsec_reg) + (TIME_W+2)'(delta_c));
                            fbeat_reg <= sat48(ext50(fbeat_reg) + ext50(ts_reg));
                        end
                    end
                    ACT_AUDIO_ON:
                    begin
                        soff_reg <= fsec_reg;
                        boff_reg <= fbeat_reg;
                        fc_reg   <= '0;
                        rate_reg <= rate_in_reg;
                    end
                    ACT_AUDIO_OFF:
                    begin
                        fsec_reg  <= s_reg;
                        fbeat_reg <= b_reg;
                        rate_reg  <= '0;
                        pend_reg  <= 1'b0;
                    end
                    ACT_ADVANCE, ACT_BLK_BEGIN:
                    begin
                        if (pend_reg)
                        begin
                            soff_reg <= pend_t_reg;
                            boff_reg <= ts_reg;
                            pend_reg <= 1'b0;
                        end
                        if (play_reg)
                            fc_reg <= fc_adv;
                        else if (pend_reg)
                            fc_reg <= '0;
                        if (act_reg == ACT_BLK_BEGIN)
                            in_blk_reg <= 1'b1;
                    end
                    ACT_SEEK:
                    begin
                        epoch_reg <= epoch_reg + 1'b1;
                        fsec_reg  <= tv_c;
                        fbeat_reg <= ts_reg;
                        video_reg <= tv_c;
                        if (offline_reg || (rate_reg == '0))
                        begin
                            pend_reg <= 1'b0;
                            fc_reg   <= '0;
                            soff_reg <= tv_c;
                            boff_reg <= ts_reg;
                        end
                        else
                        begin
                            pend_reg   <= 1'b1;
                            pend_t_reg <= tv_c;
                        end
                    end
                    ACT_OFFLINE_ON:
                    begin
                        pend_reg    <= 1'b0;
                        soff_reg    <= fsec_reg;
                        boff_reg    <= fbeat_reg;
                        fc_reg      <= '0;
                        rate_reg    <= rate_in_reg;
                        video_reg   <= fsec_reg;
                        in_blk_reg  <= 1'b0;
                        offline_reg <= 1'b1;
                    end
                    ACT_OFFLINE_OFF:
                    begin
                        pend_reg    <= 1'b0;
                        offline_reg <= 1'b0;
                        in_blk_reg  <= 1'b0;
                    end
                    ACT_VIDEO:
                        video_reg <= tv_reg;
                    ACT_BLK_END:
                        in_blk_reg <= 1'b0;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            play_reg    <= playing;
            delta_reg   <= delta_time;
            frames_reg  <= frame_count;
            rate_in_reg <= rate_hz;
            tv_reg      <= time_value;
        end
        if (cmd.op == OP_ARG)
            arg_reg <= arg_next;
        if (cmd.op == OP_MUL)
            prod_reg <= PROD_W'(mag) * PROD_W'(tempo_reg);
        if (cmd.op == OP_TS_FIN)
            ts_reg <= ts_val;
        if (cmd.op == OP_AUD_FIN)
            s_reg <= aud_val;
        if (cmd.op == OP_SEL_S)
            s_reg <= pend_reg ? pend_t_reg : (offline_reg ? video_reg : fsec_reg);
        if (cmd.op == OP_B_FIN)
            b_reg <= b_val;
        if (cmd.op == OP_OUT)
        begin
            seconds_now  <= s_reg[TIME_W-1] ? '0 : s_reg[OUT_W-1:0];
            beats_now    <= b_reg[OUT_W-1:0];
            epoch_count  <= epoch_reg;
            audio_driven <= (rate_reg != '0);
            offline_on   <= offline_reg;
        end
    end

    assign status.action   = act_reg;
    assign status.pending  = pend_reg;
    assign status.offline  = offline_reg;
    assign status.in_block = in_blk_reg;
    assign status.rate_nz  = (rate_reg != '0);
    assign status.div_busy = div_busy || dc_busy;
endmodule
`default_nettype wire

[src/mtt_ctrl.sv]
// Controller: sequences each input beat through pre-update, apply, evaluate and result.
// Depends on mtt_pkg; commands mtt_dpath.
`default_nettype none
module mtt_ctrl
    import mtt_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    input  wire status_t status,
    output cmd_t         cmd
);
    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_PREP     = 14'b00000000000010,
        S_TS_ARG   = 14'b00000000000100,
        S_TS_MUL   = 14'b00000000001000,
        S_TS_DIV   = 14'b00000000010000,
        S_TS_WAIT  = 14'b00000000100000,
        S_TS_FIN   = 14'b00000001000000,
        S_APPLY    = 14'b00000010000000,
        S_EV       = 14'b00000100000000,
        S_AUD_WAIT = 14'b00001000000000,
        S_AUD_FIN  = 14'b00010000000000,
        S_EV_B     = 14'b00100000000000,
        S_B_FIN    = 14'b01000000000000,
        S_OUT      = 14'b10000000000000
    } state_t;

    state_t   state_reg, state_next;
    arg_sel_t sel_reg, sel_next;
    logic     ev_reg, ev_next;
    logic     stop_reg, stop_next;
    logic     ov_reg, ov_next;
    logic     use_audio;

    assign use_audio = status.offline ? (status.in_block && status.rate_nz) : status.rate_nz;

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        ev_next    = ev_reg;
        stop_next  = stop_reg;
        ov_next    = ov_reg;
        cmd.op     = OP_NONE;
        cmd.sel    = sel_reg;
        if (out_ready)
            ov_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                ev_next    = 1'b0;
                stop_next  = 1'b0;
                state_next = S_APPLY;
                case (status.action)
                    ACT_TICK:
                    begin
                        sel_next   = ARG_DELTA;
                        state_next = S_TS_ARG;
                    end
                    ACT_SEEK:
                    begin
                        sel_next   = ARG_TV;
                        state_next = S_TS_ARG;
                    end
                    ACT_ADVANCE, ACT_BLK_BEGIN:
                    begin
                        if (status.pending)
                        begin
                            sel_next   = ARG_PEND;
                            state_next = S_TS_ARG;
                        end
                    end
                    ACT_AUDIO_OFF:
                    begin
                        ev_next    = 1'b1;
                        stop_next  = 1'b1;
                        state_next = S_EV;
                    end
                    default:
                        state_next = S_APPLY;
                endcase
            end
            S_TS_ARG:
            begin
                cmd.op     = OP_ARG;
                state_next = S_TS_MUL;
            end
            S_TS_MUL:
            begin
                cmd.op     = OP_MUL;
                state_next = S_TS_DIV;
            end
            S_TS_DIV:
            begin
                cmd.op     = OP_DIV_TS;
                state_next = S_TS_WAIT;
            end
            S_TS_WAIT:
            begin
                if (!status.div_busy)
                    state_next = S_TS_FIN;
            end
            S_TS_FIN:
            begin
                cmd.op     = OP_TS_FIN;
                state_next = ev_reg ? S_B_FIN : S_APPLY;
            end
            S_APPLY:
            begin
                cmd.op     = OP_APPLY;
                stop_next  = 1'b0;
                ev_next    = 1'b1;
                state_next = S_EV;
            end
            S_EV:
            begin
                if (status.pending)
                begin
                    cmd.op     = OP_SEL_S;
                    sel_next   = ARG_PEND;
                    state_next = S_TS_ARG;
                end
                else if (use_audio)
                begin
                    cmd.op     = OP_DIV_AUD;
                    state_next = S_AUD_WAIT;
                end
                else
                begin
                    cmd.op     = OP_SEL_S;
                    state_next = S_EV_B;
                end
            end
            S_AUD_WAIT:
            begin
                if (!status.div_busy)
                    state_next = S_AUD_FIN;
            end
            S_AUD_FIN:
            begin
                cmd.op     = OP_AUD_FIN;
                state_next = S_EV_B;
            end
            S_EV_B:
            begin
                if (!status.rate_nz && !status.offline)
                    state_next = S_B_FIN;
                else
                begin
                    sel_next   = ARG_DIFF;
                    state_next = S_TS_ARG;
                end
            end
            S_B_FIN:
            begin
                cmd.op     = OP_B_FIN;
                state_next = stop_reg ? S_APPLY : S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.op     = OP_OUT;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= ARG_DELTA;
            ev_reg    <= 1'b0;
            stop_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            ev_reg    <= ev_next;
            stop_reg  <= stop_next;
            ov_reg    <= ov_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
endmodule
`default_nettype wire

[src/music_transport_timebase_core.sv]
// Top level of the music transport timebase: controller plus datapath.
// Depends on mtt_pkg, mtt_if, mtt_ctrl, mtt_dpath, mtt_div.
//
//  channel   | direction | beat contents
//  in_ch     | in        | action, playing, delta_time, frame_count, rate_hz, time_value
//  out_ch    | out       | seconds_now, beats_now, epoch_count, audio_driven, offline_on
//  tempo_*   | in        | tempo_bpm write, one register, no read-back
//
// A beat that needs no tempo scaling, on the wall-clock timebase, takes the shortest path;
// the longest adds tempo scaling and an audio-time evaluation, plus any out_ch stall.
// Times are Q23.24 at the default FRAC_BITS; DIV_W, the divider width, is 48+FRAC_BITS.
// Tempo scaling runs 15 hex digits of division by 15; audio time runs the serial divider.
// Reset is asynchronous and clears all transport state; tempo returns to 120 bpm.
// A finished result holds in the output register while the next beat is accepted.
`default_nettype none
module music_transport_timebase_core
    import mtt_pkg::*;
#(
    parameter int FRAC_BITS = 24
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    mtt_in_if.sink                  in_ch,
    mtt_out_if.source               out_ch,
    input  wire logic               tempo_we,
    input  wire logic [TEMPO_W-1:0] tempo_wdata
);
    cmd_t    cmd;
    status_t status;

    mtt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    mtt_dpath #(.FRAC_BITS(FRAC_BITS)) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .tempo_we     (tempo_we),
        .tempo_wdata  (tempo_wdata),
        .action       (in_ch.action),
        .playing      (in_ch.playing),
        .delta_time   (in_ch.delta_time),
        .frame_count  (in_ch.frame_count),
        .rate_hz      (in_ch.rate_hz),
        .time_value   (in_ch.time_value),
        .seconds_now  (out_ch.seconds_now),
        .beats_now    (out_ch.beats_now),
        .epoch_count  (out_ch.epoch_count),
        .audio_driven (out_ch.audio_driven),
        .offline_on   (out_ch.offline_on)
    );
endmodule
`default_nettype wire

[src/mtt_checker.sv]
// Port-level checker for the music transport timebase, bound to the top level.
// Depends on music_transport_timebase_core_defines.svh for the assertion macros.
`default_nettype none
`include "music_transport_timebase_core_defines.svh"
module mtt_checker
    import mtt_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_ready,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire logic [OUT_W-1:0] seconds_now,
    input wire logic [OUT_W-1:0] beats_now
);
    `MTT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(seconds_now) && $stable(beats_now), "stalled result beat changed")
    `MTT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "block ready again right after accepting a beat")
    `MTT_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid), "result appeared one cycle after accept")
    `MTT_ASSERT_NOW(a_ready_on_result, $rose(out_valid), in_ready, "block not ready when a result is issued")
endmodule

bind music_transport_timebase_core mtt_checker u_mtt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .seconds_now (out_ch.seconds_now),
    .beats_now   (out_ch.beats_now)
);
`default_nettype wire
